// File: design/wto_pkg.sv
package wto_pkg;

  localparam int unsigned LenW  = 11;
  localparam int unsigned PhW   = 26;
  localparam int unsigned MulAW = 27;
  localparam int unsigned MulBW = 17;
  localparam int unsigned MulPW = MulAW + MulBW;

  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_START  = 2'd1;
  localparam logic [1:0] OP_SAMPLE = 2'd2;

  typedef struct packed {
    logic [1:0]         operation;
    logic [9:0]         table_address;
    logic signed [15:0] table_value;
    logic [25:0]        phase_increment;
    logic [15:0]        lfo_ratio;
    logic [15:0]        envelope_level;
    logic               envelope_finished;
  } in_t;

  typedef struct packed {
    logic signed [15:0] sample_out;
    logic               remove_voice;
  } out_t;

endpackage

// File: design/wavetable_oscillator_interp_top.sv
// channel | dir | handshake                | payload
// in      | in  | in_valid_i / in_stall_o  | in_data_i  (wto_pkg::in_t)
// out     | out | out_valid_o / out_stall_i| out_data_o (wto_pkg::out_t)
// cfg     | in  | cfg_we_i                 | cfg_data_i (table_length)
//
// Table write, note start and unknown ops: state stays idle, ready again next cycle.
// Sample: accept plus four steps (read, step, interpolate, scale) on the one
// shared multiplier, after a compare-subtract reduction when the phase sits past
// a shortened table_length. Saturation waits while the output register is held.
// Async reset: table_length 1024, phase and base step zero, table undefined.
module wavetable_oscillator_interp_top #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  wto_pkg::in_t         in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output wto_pkg::out_t        out_data_o,
  input  logic                 cfg_we_i,
  input  logic [10:0]          cfg_data_i
);

  import wto_pkg::*;

  localparam int unsigned AddrW  = $clog2(TABLE_DEPTH);
  localparam int unsigned LenLim = (TABLE_DEPTH < 1024) ? TABLE_DEPTH : 1024;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MOD  = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_STEP = 3'd3;
  localparam logic [2:0] S_INT  = 3'd4;
  localparam logic [2:0] S_SAT  = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [3:0]       cnt_q, cnt_d;
  logic [LenW-1:0]  tlen_q;
  logic [PhW-1:0]   phase_q, phase_d;
  logic [PhW-1:0]   base_q, base_d;
  logic [15:0]      lfo_q;
  logic [15:0]      env_q;
  logic             fin_q;
  logic             out_valid_q;
  out_t             out_q;

  logic             in_acc;
  logic [LenW-1:0]  len;
  logic [26:0]      lenq;
  logic [9:0]       idx;
  logic [9:0]       nxt;
  logic [16:0]      waddr_ext, raddr_a_ext, raddr_b_ext;
  logic             ram_we;
  logic             ram_re;
  logic signed [15:0] rd_a, rd_b;

  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [MulPW-1:0] mul_p;
  logic             mul_en;

  logic [20:0]      trial;
  logic [27:0]      step_raw;
  logic [PhW-1:0]   step_c;
  logic [26:0]      ph_sum;
  logic signed [MulPW-1:0] scaled;
  logic signed [15:0] sat_val;
  logic             out_free;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !(out_valid_q && out_stall_i);

  always_comb begin
    len = tlen_q;
    if (len < LenW'(2)) begin
      len = LenW'(2);
    end else if (len > LenW'(LenLim)) begin
      len = LenW'(LenLim);
    end
  end

  assign lenq = {len, 16'd0};
  assign idx  = phase_q[PhW-1:16];
  assign nxt  = ({1'b0, idx} + 11'd1 >= len) ? 10'd0 : idx + 10'd1;

  assign waddr_ext   = {7'd0, in_data_i.table_address};
  assign raddr_a_ext = {7'd0, idx};
  assign raddr_b_ext = {7'd0, nxt};
  assign ram_we      = in_acc && (in_data_i.operation == OP_WRITE)
                       && (waddr_ext < 17'(TABLE_DEPTH));
  assign ram_re      = (state_q == S_RD);

  wto_ram #(
    .Depth (TABLE_DEPTH),
    .AddrW (AddrW)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (waddr_ext[AddrW-1:0]),
    .wdata_i   (in_data_i.table_value),
    .re_i      (ram_re),
    .raddr_a_i (raddr_a_ext[AddrW-1:0]),
    .raddr_b_i (raddr_b_ext[AddrW-1:0]),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_RD: begin
        mul_a = {1'b0, base_q};
        mul_b = {1'b0, lfo_q};
      end
      S_STEP: begin
        mul_a = MulAW'(signed'({rd_b[15], rd_b}) - signed'({rd_a[15], rd_a}));
        mul_b = {1'b0, phase_q[15:0]};
      end
      S_INT: begin
        mul_a = MulAW'(signed'(rd_a)) + mul_p[42:16];
        mul_b = {1'b0, env_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // keep the scaled product while the result waits for the output register
  assign mul_en = (state_q != S_SAT);

  wto_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  // step clamp and phase advance
  assign trial    = 21'(len) << cnt_q;
  assign step_raw = mul_p[41:14];
  assign step_c   = (step_raw > 28'(lenq - 27'd1)) ? PhW'(lenq - 27'd1) : step_raw[PhW-1:0];
  assign ph_sum   = {1'b0, phase_q} + {1'b0, step_c};

  assign scaled = mul_p >>> 15;
  always_comb begin
    if (scaled > MulPW'(signed'(32767))) begin
      sat_val = 16'sh7FFF;
    end else if (scaled < -MulPW'(signed'(32768))) begin
      sat_val = -16'sh8000;
    end else begin
      sat_val = scaled[15:0];
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    phase_d = phase_q;
    base_d  = base_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (in_data_i.operation)
            OP_START: begin
              base_d = in_data_i.phase_increment;
              if (in_data_i.envelope_finished) begin
                phase_d = '0;
              end
            end
            OP_SAMPLE: begin
              cnt_d   = 4'd9;
              state_d = ({1'b0, idx} >= len) ? S_MOD : S_RD;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_MOD: begin
        // restoring reduction of the integer phase by len
        if ({11'd0, idx} >= trial) begin
          phase_d[PhW-1:16] = idx - trial[9:0];
        end
        cnt_d = cnt_q - 4'd1;
        if (cnt_q == 4'd0) begin
          state_d = S_RD;
        end
      end
      S_RD: begin
        state_d = S_STEP;
      end
      S_STEP: begin
        phase_d = (ph_sum >= lenq) ? PhW'(ph_sum - lenq) : ph_sum[PhW-1:0];
        state_d = S_INT;
      end
      S_INT: begin
        state_d = S_SAT;
      end
      S_SAT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      phase_q     <= '0;
      base_q      <= '0;
      tlen_q      <= LenW'(1024);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      phase_q <= phase_d;
      base_q  <= base_d;
      if (cfg_we_i) begin
        tlen_q <= cfg_data_i;
      end
      if (state_q == S_SAT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      lfo_q <= in_data_i.lfo_ratio;
      env_q <= in_data_i.envelope_level;
      fin_q <= in_data_i.envelope_finished;
    end
    if (state_q == S_SAT && out_free) begin
      out_q.sample_out   <= sat_val;
      out_q.remove_voice <= fin_q;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_SAT))
    else $error("result beat appeared outside the scale step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_STEP) |=> ({1'b0, phase_q[PhW-1:16]} < $past(len)))
    else $error("phase not wrapped below table length");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_data_i.operation == OP_SAMPLE) |=> (state_q == S_MOD || state_q == S_RD))
    else $error("sample beat did not start the sequencer");

endmodule

// File: design/wto_ram.sv
module wto_ram #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = 10
) (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [AddrW-1:0]        waddr_i,
  input  logic signed [15:0]      wdata_i,
  input  logic                    re_i,
  input  logic [AddrW-1:0]        raddr_a_i,
  input  logic [AddrW-1:0]        raddr_b_i,
  output logic signed [15:0]      rdata_a_o,
  output logic signed [15:0]      rdata_b_o
);

  logic signed [15:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // two read ports, data held between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

// File: design/wto_mul.sv
module wto_mul (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic signed [wto_pkg::MulAW-1:0] a_i,
  input  logic signed [wto_pkg::MulBW-1:0] b_i,
  output logic signed [wto_pkg::MulPW-1:0] p_o
);

  import wto_pkg::*;

  // product holds while en_i is low
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_o <= a_i * b_i;
    end
  end

endmodule
